>>> hdl/rtcf_pkg.sv
// shared types, constants and register codes for the raised-cosine fade block
// no dependencies
`timescale 1ns / 1ps

package rtcf_pkg;

  localparam int CHANNELS         = 4;
  localparam int TABLE_SIZE_DEF   = 1024;
  localparam int SAMPLE_W         = 24;
  localparam int GAIN_W           = 17;
  localparam int LEN_W            = 20;
  localparam int STEP_W           = 27;
  localparam int COUNT_W          = 19;
  localparam int CFG_IDX_W        = 3;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;
  localparam logic [LEN_W-1:0]  MAX_LEN    = 20'd524288;

  localparam logic [LEN_W-1:0]  START_LEN_RST  = 20'd1200;
  localparam logic [LEN_W-1:0]  END_LEN_RST    = 20'd1200;
  localparam logic [STEP_W-1:0] START_STEP_RST = 27'd55924;
  localparam logic [STEP_W-1:0] END_STEP_RST   = 27'd55924;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_LEN  = 3'd0,
    REG_END_LEN    = 3'd1,
    REG_START_STEP = 3'd2,
    REG_END_STEP   = 3'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INDEX,
    ST_LOOKUP,
    ST_WEIGHT,
    ST_GAIN,
    ST_SCALE
  } state_t;

  typedef struct packed {
    logic                       rolling;
    logic signed [SAMPLE_W-1:0] sample_in_0;
    logic signed [SAMPLE_W-1:0] sample_in_1;
    logic signed [SAMPLE_W-1:0] sample_in_2;
    logic signed [SAMPLE_W-1:0] sample_in_3;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out_0;
    logic signed [SAMPLE_W-1:0] sample_out_1;
    logic signed [SAMPLE_W-1:0] sample_out_2;
    logic signed [SAMPLE_W-1:0] sample_out_3;
    logic [GAIN_W-1:0]          applied_gain;
  } out_t;

  // sequencer strobes towards the datapath
  typedef struct packed {
    logic accept;
    logic index;
    logic weight;
    logic gain;
    logic scale;
  } ctl_t;

endpackage

>>> hdl/transport_raised_cosine_fade_core.sv
// top level of the transport fade: ramp sequencer, rom lookup, channel lanes
// depends on rtcf_pkg, rtcf_rom, rtcf_lane
`timescale 1ns / 1ps

// a request accepted in idle walks the index, lookup, weight, gain and scale states;
//   out_valid is registered as the scale state completes
// no new frame is taken until the ramp sequencer has walked index multiply, rom read,
//   weight multiply, gain update and lane scaling; the scale step waits on a full output slot
// a frame is accepted while an earlier result still waits on the output
// reset (rst_n low, synchronous) returns ramp state to zero gain, stopped,
//   and the config registers to 1200 / 1200 / 55924 / 55924; no clearing pass
module transport_raised_cosine_fade_core #(
  parameter int TABLE_SIZE = rtcf_pkg::TABLE_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rtcf_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rtcf_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtcf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtcf_pkg::STEP_W-1:0]       cfg_data
);

  localparam int IW    = $clog2(TABLE_SIZE);
  localparam int PW    = rtcf_pkg::COUNT_W + rtcf_pkg::STEP_W;
  localparam int HW    = PW - 16;
  localparam int GW    = rtcf_pkg::GAIN_W;
  localparam int SW    = rtcf_pkg::SAMPLE_W;
  localparam int NCH   = rtcf_pkg::CHANNELS;
  localparam logic [HW-1:0] IDX_MAX = HW'(TABLE_SIZE - 1);

  // config registers
  logic [rtcf_pkg::LEN_W-1:0]  start_len_r, end_len_r;
  logic [rtcf_pkg::STEP_W-1:0] start_step_r, end_step_r;

  // ramp state
  logic                         prev_rolling_r;
  logic [GW-1:0]                ramp_start_r, ramp_target_r, cur_gain_r;
  logic [rtcf_pkg::COUNT_W-1:0] counter_r;
  logic                         fading_out_r;
  logic [GW-1:0]                gain_calc;

  // datapath registers
  logic [PW-1:0]     idx_prod_r;
  logic [2*GW-1:0]   wprod_r;
  logic signed [SW-1:0] sample_r [NCH];

  rtcf_pkg::state_t state_r, state_nxt;
  rtcf_pkg::ctl_t   ctl;

  logic           out_valid_r;
  rtcf_pkg::out_t out_r;

  // ---------------- config port, always ready (writes only while idle is a rule for the user; not enforced here)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_len_r  <= rtcf_pkg::START_LEN_RST;
      end_len_r    <= rtcf_pkg::END_LEN_RST;
      start_step_r <= rtcf_pkg::START_STEP_RST;
      end_step_r   <= rtcf_pkg::END_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (rtcf_pkg::cfg_reg_t'(cfg_index))
        rtcf_pkg::REG_START_LEN:  start_len_r  <= cfg_data[rtcf_pkg::LEN_W-1:0];
        rtcf_pkg::REG_END_LEN:    end_len_r    <= cfg_data[rtcf_pkg::LEN_W-1:0];
        rtcf_pkg::REG_START_STEP: start_step_r <= cfg_data;
        rtcf_pkg::REG_END_STEP:   end_step_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rtcf_pkg::ST_IDLE:   if (in_valid) state_nxt = rtcf_pkg::ST_INDEX;
      rtcf_pkg::ST_INDEX:  state_nxt = rtcf_pkg::ST_LOOKUP;
      rtcf_pkg::ST_LOOKUP: state_nxt = rtcf_pkg::ST_WEIGHT;
      rtcf_pkg::ST_WEIGHT: state_nxt = rtcf_pkg::ST_GAIN;
      rtcf_pkg::ST_GAIN:   state_nxt = rtcf_pkg::ST_SCALE;
      rtcf_pkg::ST_SCALE:  if (!(out_valid_r && out_stall)) state_nxt = rtcf_pkg::ST_IDLE;
      default:             state_nxt = rtcf_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs; the scale step waits while the output slot is still full
  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    case (state_r)
      rtcf_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        ctl.accept = in_valid;
      end
      rtcf_pkg::ST_INDEX:  ctl.index  = 1'b1;
      rtcf_pkg::ST_WEIGHT: ctl.weight = 1'b1;
      rtcf_pkg::ST_GAIN:   ctl.gain   = 1'b1;
      rtcf_pkg::ST_SCALE:  ctl.scale  = !(out_valid_r && out_stall);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rtcf_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------- ramp start on a transport edge
  logic [rtcf_pkg::LEN_W-1:0]   len_sel, len_clamped;
  logic [rtcf_pkg::COUNT_W-1:0] count_init;

  always_comb begin
    len_sel = in_data.rolling ? start_len_r : end_len_r;
    if (len_sel == '0)                  len_clamped = 20'd1;
    else if (len_sel > rtcf_pkg::MAX_LEN) len_clamped = rtcf_pkg::MAX_LEN;
    else                                len_clamped = len_sel;
    count_init = rtcf_pkg::COUNT_W'(len_clamped - 20'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_rolling_r <= 1'b0;
      ramp_start_r   <= '0;
      ramp_target_r  <= '0;
      counter_r      <= '0;
      fading_out_r   <= 1'b0;
      cur_gain_r     <= '0;
    end else begin
      if (ctl.accept) begin
        prev_rolling_r <= in_data.rolling;
        if (in_data.rolling != prev_rolling_r) begin
          ramp_start_r  <= cur_gain_r;
          counter_r     <= count_init;
          ramp_target_r <= in_data.rolling ? rtcf_pkg::UNITY_GAIN : '0;
          fading_out_r  <= !in_data.rolling;
        end
      end
      // counter counts down after its index product is taken, holds at zero
      if (ctl.index && counter_r != '0) counter_r <= counter_r - 1'b1;
      if (ctl.gain) cur_gain_r <= gain_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      sample_r[0] <= in_data.sample_in_0;
      sample_r[1] <= in_data.sample_in_1;
      sample_r[2] <= in_data.sample_in_2;
      sample_r[3] <= in_data.sample_in_3;
    end
  end

  // ---------------- index multiply, rom lookup, weight multiply
  logic [rtcf_pkg::STEP_W-1:0] step_sel;
  logic [HW-1:0]               idx_full;
  logic [IW-1:0]               rom_addr;
  logic [GW-1:0]               weight;

  assign step_sel = fading_out_r ? end_step_r : start_step_r;
  assign idx_full = idx_prod_r[PW-1:16];
  // index beyond the table sticks at the last entry
  assign rom_addr = (idx_full > IDX_MAX) ? IDX_MAX[IW-1:0] : idx_full[IW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.index) idx_prod_r <= PW'(counter_r) * PW'(step_sel);
  end

  rtcf_rom #(.TABLE_SIZE(TABLE_SIZE)) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (weight)
  );

  logic          ramp_up;
  logic [GW-1:0] diff;

  assign ramp_up = ramp_target_r >= ramp_start_r;
  assign diff    = ramp_up ? ramp_target_r - ramp_start_r : ramp_start_r - ramp_target_r;

  always_ff @(posedge clk) begin
    if (ctl.weight) wprod_r <= (2*GW)'(diff) * (2*GW)'(weight);
  end

  // ---------------- gain update, magnitude term truncates towards zero
  logic [GW:0]   delta, gain_sum;

  always_comb begin
    delta = (GW+1)'(wprod_r >> 16);
    if (ramp_up) gain_sum = {1'b0, ramp_start_r} + delta;
    else         gain_sum = {1'b0, ramp_start_r} - delta;
    if (gain_sum > {1'b0, rtcf_pkg::UNITY_GAIN}) gain_calc = rtcf_pkg::UNITY_GAIN;
    else                                          gain_calc = gain_sum[GW-1:0];
  end

  // ---------------- channel lanes and merge into the output slot
  logic signed [SW-1:0] lane_out [NCH];

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    rtcf_lane u_lane (
      .sample (sample_r[c]),
      .gain   (cur_gain_r),
      .scaled (lane_out[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (ctl.scale) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.scale) begin
      out_r.sample_out_0 <= lane_out[0];
      out_r.sample_out_1 <= lane_out[1];
      out_r.sample_out_2 <= lane_out[2];
      out_r.sample_out_3 <= lane_out[3];
      out_r.applied_gain <= cur_gain_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------- checks
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == rtcf_pkg::ST_INDEX)
    else $error("accepted frame did not start the sequencer");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != rtcf_pkg::ST_IDLE) |-> in_stall)
    else $error("input taken while a frame is in flight");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_gain_r <= rtcf_pkg::UNITY_GAIN)
    else $error("gain above unity");

  a_out_gain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_r.applied_gain == cur_gain_r)
    else $error("output gain differs from ramp gain");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !ctl.scale)
    else $error("pending result overwritten");

endmodule

>>> hdl/rtcf_rom.sv
// half-cosine weight rom, entries built at elaboration, registered read
// depends on rtcf_pkg
`timescale 1ns / 1ps

module rtcf_rom #(
  parameter int TABLE_SIZE = rtcf_pkg::TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic [$clog2(TABLE_SIZE)-1:0] addr,
  output logic [rtcf_pkg::GAIN_W-1:0]   q
);

  logic [rtcf_pkg::GAIN_W-1:0] rom_tbl [TABLE_SIZE];
  logic [rtcf_pkg::GAIN_W-1:0] q_r;

  // cos(y) by a nested taylor form in q30, squared into q16
  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_ent
    localparam logic [63:0] ONE = rtcf_pkg::ONE_Q30;
    localparam logic [63:0] Y   = (64'(i) * rtcf_pkg::PI_Q30) / (2 * TABLE_SIZE);
    localparam logic [63:0] Y2  = (Y * Y) >> 30;
    localparam logic [63:0] Q1  = ((Y2 * ONE) >> 30) / 132;
    localparam logic [63:0] T1  = (Q1 >= ONE) ? 64'd0 : ONE - Q1;
    localparam logic [63:0] Q2  = ((Y2 * T1) >> 30) / 90;
    localparam logic [63:0] T2  = (Q2 >= ONE) ? 64'd0 : ONE - Q2;
    localparam logic [63:0] Q3  = ((Y2 * T2) >> 30) / 56;
    localparam logic [63:0] T3  = (Q3 >= ONE) ? 64'd0 : ONE - Q3;
    localparam logic [63:0] Q4  = ((Y2 * T3) >> 30) / 30;
    localparam logic [63:0] T4  = (Q4 >= ONE) ? 64'd0 : ONE - Q4;
    localparam logic [63:0] Q5  = ((Y2 * T4) >> 30) / 12;
    localparam logic [63:0] T5  = (Q5 >= ONE) ? 64'd0 : ONE - Q5;
    localparam logic [63:0] P   = ((Y2 * T5) >> 30) / 2;
    localparam logic [63:0] C   = (P >= ONE) ? 64'd0 : ONE - P;
    localparam logic [63:0] E   = (C * C + (64'd1 << 43)) >> 44;
    assign rom_tbl[i] = E[rtcf_pkg::GAIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    q_r <= rom_tbl[addr];
  end

  assign q = q_r;

endmodule

>>> hdl/rtcf_lane.sv
// one channel lane: sample times q16 gain, floored back to 24 bits
// depends on rtcf_pkg
`timescale 1ns / 1ps

module rtcf_lane (
  input  logic signed [rtcf_pkg::SAMPLE_W-1:0] sample,
  input  logic [rtcf_pkg::GAIN_W-1:0]          gain,
  output logic signed [rtcf_pkg::SAMPLE_W-1:0] scaled
);

  logic signed [rtcf_pkg::SAMPLE_W+rtcf_pkg::GAIN_W:0] prod;

  // arithmetic shift gives floor for negative products
  assign prod   = sample * $signed({1'b0, gain});
  assign scaled = prod[rtcf_pkg::SAMPLE_W+15:16];

endmodule
